// ----- design/hrp_pkg.sv -----
package hrp_pkg;

    // one received header byte
    typedef struct packed {
        logic [7:0] data_byte;
        logic       first_byte;
    } hrp_in_t;

    // one parse result
    typedef struct packed {
        logic [15:0] status_code;
        logic        status_ok;
        logic        length_known;
        logic [47:0] content_length;
        logic [31:0] transfer_length;
        logic [15:0] header_bytes;
        logic [1:0]  outcome;
    } hrp_out_t;

    // configuration registers as seen by the parse core
    typedef struct packed {
        logic [15:0] max_header_bytes;
        logic [31:0] transfer_limit;
        logic [7:0]  line_limit;
    } hrp_cfg_t;

    localparam logic [7:0] CFG_IDX_MAX_HEADER_BYTES = 8'd0;
    localparam logic [7:0] CFG_IDX_TRANSFER_LIMIT   = 8'd1;
    localparam logic [7:0] CFG_IDX_LINE_LIMIT       = 8'd2;

    localparam logic [15:0] MAX_HEADER_BYTES_RST = 16'd1500;
    localparam logic [31:0] TRANSFER_LIMIT_RST   = 32'd140000;
    localparam logic [7:0]  LINE_LIMIT_RST       = 8'd10;

    localparam logic [1:0] OUTCOME_SUCCESS  = 2'd0;
    localparam logic [1:0] OUTCOME_OVERFLOW = 2'd1;
    localparam logic [1:0] OUTCOME_NOT_2XX  = 2'd2;

    localparam logic [15:0] STATUS_DEFAULT = 16'd400;
    localparam logic [15:0] STATUS_OK_LO   = 16'd200;
    localparam logic [15:0] STATUS_OK_HI   = 16'd300;

    localparam logic [7:0] CHAR_CR    = 8'h0D;
    localparam logic [7:0] CHAR_LF    = 8'h0A;
    localparam logic [7:0] CHAR_SPACE = 8'h20;
    localparam logic [7:0] CHAR_COLON = 8'h3A;
    localparam logic [7:0] CHAR_ZERO  = 8'h30;
    localparam logic [7:0] CHAR_NINE  = 8'h39;

    localparam logic [3:0] KEY_LEN = 4'd14;

    // "Content-Length", one character per match position
    function automatic logic [7:0] key_char(input logic [3:0] pos);
        logic [7:0] c;
        case (pos)
            4'd0:    c = 8'h43; // C
            4'd1:    c = 8'h6F; // o
            4'd2:    c = 8'h6E; // n
            4'd3:    c = 8'h74; // t
            4'd4:    c = 8'h65; // e
            4'd5:    c = 8'h6E; // n
            4'd6:    c = 8'h74; // t
            4'd7:    c = 8'h2D; // -
            4'd8:    c = 8'h4C; // L
            4'd9:    c = 8'h65; // e
            4'd10:   c = 8'h6E; // n
            4'd11:   c = 8'h67; // g
            4'd12:   c = 8'h74; // t
            4'd13:   c = 8'h68; // h
            default: c = 8'h00;
        endcase
        return c;
    endfunction

endpackage

// ----- design/hrp_in_stage.sv -----
module hrp_in_stage (
    input  logic            aclk,
    input  logic            aresetn,
    input  logic            s_valid,
    output logic            s_ready,
    input  hrp_pkg::hrp_in_t s_data,
    output logic            item_valid,
    output hrp_pkg::hrp_in_t item,
    input  logic            item_take
);

    logic             valid_reg;
    hrp_pkg::hrp_in_t data_reg;

    // refill in the same cycle the held item moves on
    assign s_ready    = !valid_reg || item_take;
    assign item_valid = valid_reg;
    assign item       = data_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= 1'b0;
        end else if (s_valid && s_ready) begin
            valid_reg <= 1'b1;
        end else if (item_take) begin
            valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (s_valid && s_ready) begin
            data_reg <= s_data;
        end
    end

endmodule

// ----- design/hrp_core.sv -----
module hrp_core #(
    parameter int COUNT_WIDTH  = 16,
    parameter int LENGTH_WIDTH = 48
) (
    input  logic              aclk,
    input  logic              aresetn,
    input  hrp_pkg::hrp_cfg_t cfg,
    input  logic              item_valid,
    input  hrp_pkg::hrp_in_t  item,
    input  logic              out_free,
    output logic              item_take,
    output logic              res_valid,
    output hrp_pkg::hrp_out_t res
);

    localparam logic [2:0] PH_PREFIX = 3'd0;
    localparam logic [2:0] PH_COLON  = 3'd1;
    localparam logic [2:0] PH_SPACES = 3'd2;
    localparam logic [2:0] PH_DIGITS = 3'd3;
    localparam logic [2:0] PH_IGNORE = 3'd4;

    localparam logic [1:0] FL_BEFORE = 2'd0;
    localparam logic [1:0] FL_SPACES = 2'd1;
    localparam logic [1:0] FL_DIGITS = 2'd2;
    localparam logic [1:0] FL_DONE   = 2'd3;

    localparam int CMP_W = (COUNT_WIDTH > 16) ? COUNT_WIDTH : 16;
    localparam int LEN_EXT_W = (LENGTH_WIDTH > 48) ? LENGTH_WIDTH : 48;
    localparam logic [COUNT_WIDTH-1:0] CMAX = {COUNT_WIDTH{1'b1}};
    localparam logic [LENGTH_WIDTH-1:0] LMAX = {LENGTH_WIDTH{1'b1}};

    logic [COUNT_WIDTH-1:0]  byte_count_reg, byte_count_next, cnt_cur;
    logic [23:0]             tail_bytes_reg, tail_bytes_next, tail_cur;
    logic [7:0]              line_index_reg, line_index_next, line_cur;
    logic [2:0]              line_phase_reg, line_phase_next, lph_cur;
    logic [3:0]              prefix_pos_reg, prefix_pos_next, pos_cur;
    logic [1:0]              fl_phase_reg, fl_phase_next, fl_cur;
    logic [15:0]             status_reg, status_next, status_cur;
    logic                    status_seen_reg, status_seen_next, seen_cur;
    logic [LENGTH_WIDTH-1:0] length_reg, length_next, len_cur;
    logic                    length_found_reg, length_found_next, found_cur;
    logic                    active_reg, active_next;

    logic                    act, is_digit, term, over;
    logic [7:0]              b;
    logic [3:0]              d;
    logic [15:0]             status_base;
    logic [19:0]             status_wide;
    logic [15:0]             status_sat;
    logic [LENGTH_WIDTH+3:0] len_wide;
    logic [LENGTH_WIDTH-1:0] len_sat;
    logic [LENGTH_WIDTH-1:0] lim_ext, tlen;
    logic [LEN_EXT_W-1:0]    len_out;
    logic [CMP_W-1:0]        cnt_out;

    assign item_take = item_valid && out_free;
    assign b         = item.data_byte;
    assign act       = item.first_byte || active_reg;
    assign is_digit  = (b >= hrp_pkg::CHAR_ZERO) && (b <= hrp_pkg::CHAR_NINE);
    assign d         = is_digit ? 4'(b - hrp_pkg::CHAR_ZERO) : 4'd0;

    // starting byte sees cleared parse state
    always_comb begin
        if (item.first_byte) begin
            cnt_cur    = '0;
            tail_cur   = '0;
            line_cur   = '0;
            lph_cur    = PH_PREFIX;
            pos_cur    = '0;
            fl_cur     = FL_BEFORE;
            status_cur = hrp_pkg::STATUS_DEFAULT;
            seen_cur   = 1'b0;
            len_cur    = '0;
            found_cur  = 1'b0;
        end else begin
            cnt_cur    = byte_count_reg;
            tail_cur   = tail_bytes_reg;
            line_cur   = line_index_reg;
            lph_cur    = line_phase_reg;
            pos_cur    = prefix_pos_reg;
            fl_cur     = fl_phase_reg;
            status_cur = status_reg;
            seen_cur   = status_seen_reg;
            len_cur    = length_reg;
            found_cur  = length_found_reg;
        end
    end

    // acc*10 + d by shift-add; any carry past the width saturates
    always_comb begin
        status_base = seen_cur ? status_cur : 16'd0;
        status_wide = ({4'd0, status_base} << 3) + ({4'd0, status_base} << 1) + 20'(d);
        status_sat  = (status_wide[19:16] != 4'd0) ? 16'hFFFF : status_wide[15:0];
        len_wide    = ({4'd0, len_cur} << 3) + ({4'd0, len_cur} << 1)
                    + (LENGTH_WIDTH+4)'(d);
        len_sat     = (len_wide[LENGTH_WIDTH+3:LENGTH_WIDTH] != 4'd0) ? LMAX
                    : len_wide[LENGTH_WIDTH-1:0];
    end

    always_comb begin
        byte_count_next   = (cnt_cur != CMAX) ? cnt_cur + 1'b1 : cnt_cur;
        tail_bytes_next   = {tail_cur[15:0], b};
        line_index_next   = line_cur;
        line_phase_next   = lph_cur;
        prefix_pos_next   = pos_cur;
        fl_phase_next     = fl_cur;
        status_next       = status_cur;
        status_seen_next  = seen_cur;
        length_next       = len_cur;
        length_found_next = found_cur;

        // status code on line one
        if (b == hrp_pkg::CHAR_LF) begin
            fl_phase_next = FL_DONE;
        end else if (fl_cur == FL_BEFORE) begin
            if (b == hrp_pkg::CHAR_SPACE) begin
                fl_phase_next = FL_SPACES;
            end
        end else if (fl_cur == FL_SPACES || fl_cur == FL_DIGITS) begin
            if (b == hrp_pkg::CHAR_SPACE && fl_cur == FL_SPACES) begin
                fl_phase_next = FL_SPACES;
            end else if (is_digit) begin
                status_next      = status_sat;
                status_seen_next = 1'b1;
                fl_phase_next    = FL_DIGITS;
            end else begin
                fl_phase_next = FL_DONE;
            end
        end

        // Content-Length scan
        if (b == hrp_pkg::CHAR_LF) begin
            if (line_cur != 8'hFF) begin
                line_index_next = line_cur + 8'd1;
            end
            line_phase_next = PH_PREFIX;
            prefix_pos_next = '0;
        end else if (line_cur < cfg.line_limit) begin
            case (lph_cur)
                PH_PREFIX: begin
                    if (pos_cur < hrp_pkg::KEY_LEN && b == hrp_pkg::key_char(pos_cur)) begin
                        prefix_pos_next = pos_cur + 4'd1;
                        if (pos_cur + 4'd1 == hrp_pkg::KEY_LEN) begin
                            length_found_next = 1'b1;
                            length_next       = '0;
                            line_phase_next   = PH_COLON;
                        end
                    end else begin
                        line_phase_next = PH_IGNORE;
                    end
                end
                PH_COLON: begin
                    if (b == hrp_pkg::CHAR_COLON) begin
                        line_phase_next = PH_SPACES;
                    end
                end
                PH_SPACES, PH_DIGITS: begin
                    if (b == hrp_pkg::CHAR_SPACE && lph_cur == PH_SPACES) begin
                        line_phase_next = PH_SPACES;
                    end else if (is_digit) begin
                        length_next     = len_sat;
                        line_phase_next = PH_DIGITS;
                    end else begin
                        line_phase_next = PH_IGNORE;
                    end
                end
                default: begin
                    line_phase_next = lph_cur;
                end
            endcase
        end

        term = (byte_count_next > COUNT_WIDTH'(4)) && (tail_cur == 24'h0D0A0D)
             && (b == hrp_pkg::CHAR_LF);
        over = !term && ((CMP_W'(byte_count_next) >= CMP_W'(cfg.max_header_bytes))
             || (byte_count_next == CMAX));
        active_next = !(term || over);
    end

    // result fields from the updated state
    always_comb begin
        lim_ext = LENGTH_WIDTH'(cfg.transfer_limit);
        tlen    = (length_found_next && length_next < lim_ext) ? length_next : lim_ext;
        len_out = LEN_EXT_W'(length_next);
        cnt_out = CMP_W'(byte_count_next);

        res.status_code     = status_next;
        res.status_ok       = (status_next >= hrp_pkg::STATUS_OK_LO)
                            && (status_next < hrp_pkg::STATUS_OK_HI);
        res.length_known    = length_found_next;
        res.content_length  = len_out[47:0];
        res.transfer_length = tlen[31:0];
        res.header_bytes    = cnt_out[15:0];
        if (over) begin
            res.outcome = hrp_pkg::OUTCOME_OVERFLOW;
        end else if (res.status_ok) begin
            res.outcome = hrp_pkg::OUTCOME_SUCCESS;
        end else begin
            res.outcome = hrp_pkg::OUTCOME_NOT_2XX;
        end
    end

    assign res_valid = item_take && act && (term || over);

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            active_reg <= 1'b0;
        end else if (item_take && act) begin
            active_reg <= active_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (item_take && act) begin
            byte_count_reg   <= byte_count_next;
            tail_bytes_reg   <= tail_bytes_next;
            line_index_reg   <= line_index_next;
            line_phase_reg   <= line_phase_next;
            prefix_pos_reg   <= prefix_pos_next;
            fl_phase_reg     <= fl_phase_next;
            status_reg       <= status_next;
            status_seen_reg  <= status_seen_next;
            length_reg       <= length_next;
            length_found_reg <= length_found_next;
        end
    end

endmodule

// ----- design/hrp_out_stage.sv -----
module hrp_out_stage (
    input  logic              aclk,
    input  logic              aresetn,
    input  logic              res_valid,
    input  hrp_pkg::hrp_out_t res,
    output logic              out_free,
    output logic              m_valid,
    input  logic              m_ready,
    output hrp_pkg::hrp_out_t m_data
);

    logic              valid_reg;
    hrp_pkg::hrp_out_t data_reg;

    assign out_free = !valid_reg || m_ready;
    assign m_valid  = valid_reg;
    assign m_data   = data_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= 1'b0;
        end else if (out_free) begin
            valid_reg <= res_valid;
        end
    end

    always_ff @(posedge aclk) begin
        if (out_free && res_valid) begin
            data_reg <= res;
        end
    end

endmodule

// ----- design/http_response_header_parser.sv -----
// A byte accepted into the input register is parsed from there; a result it causes
// is captured in the result register as that byte is taken, then shown on m_data.
// Throughput: one byte per cycle, set by the single-pass per-byte state update.
// A byte waits in the input register, and the rate drops, while a result is held unread.
// Reset (aresetn low, synchronous): no response active, both stages empty,
// configuration back to 1500 / 140000 / 10.
module http_response_header_parser #(
    parameter int COUNT_WIDTH  = 16,
    parameter int LENGTH_WIDTH = 48
) (
    input  logic              aclk,
    input  logic              aresetn,

    // header byte stream
    input  logic              s_valid,
    output logic              s_ready,
    input  hrp_pkg::hrp_in_t  s_data,

    // parse results
    output logic              m_valid,
    input  logic              m_ready,
    output hrp_pkg::hrp_out_t m_data,

    // configuration writes
    input  logic              cfg_valid,
    output logic              cfg_ready,
    input  logic [7:0]        cfg_index,
    input  logic [31:0]       cfg_data
);

    hrp_pkg::hrp_cfg_t cfg_reg;
    hrp_pkg::hrp_in_t  item;
    hrp_pkg::hrp_out_t res;
    logic              item_valid;
    logic              item_take;
    logic              out_free;
    logic              res_valid;

    // config writes always land; indexes past the list are dropped
    assign cfg_ready = 1'b1;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cfg_reg.max_header_bytes <= hrp_pkg::MAX_HEADER_BYTES_RST;
            cfg_reg.transfer_limit   <= hrp_pkg::TRANSFER_LIMIT_RST;
            cfg_reg.line_limit       <= hrp_pkg::LINE_LIMIT_RST;
        end else if (cfg_valid && cfg_ready) begin
            case (cfg_index)
                hrp_pkg::CFG_IDX_MAX_HEADER_BYTES: begin
                    cfg_reg.max_header_bytes <= cfg_data[15:0];
                end
                hrp_pkg::CFG_IDX_TRANSFER_LIMIT: begin
                    cfg_reg.transfer_limit <= cfg_data;
                end
                hrp_pkg::CFG_IDX_LINE_LIMIT: begin
                    cfg_reg.line_limit <= cfg_data[7:0];
                end
                default: begin
                    cfg_reg <= cfg_reg;
                end
            endcase
        end
    end

    // input register: holds the byte being parsed this cycle
    hrp_in_stage u_in (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .s_valid    (s_valid),
        .s_ready    (s_ready),
        .s_data     (s_data),
        .item_valid (item_valid),
        .item       (item),
        .item_take  (item_take)
    );

    // per-byte parse state and result formation
    hrp_core #(
        .COUNT_WIDTH  (COUNT_WIDTH),
        .LENGTH_WIDTH (LENGTH_WIDTH)
    ) u_core (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .cfg        (cfg_reg),
        .item_valid (item_valid),
        .item       (item),
        .out_free   (out_free),
        .item_take  (item_take),
        .res_valid  (res_valid),
        .res        (res)
    );

    // result register: parts the result side from the parse side
    hrp_out_stage u_out (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .res_valid (res_valid),
        .res       (res),
        .out_free  (out_free),
        .m_valid   (m_valid),
        .m_ready   (m_ready),
        .m_data    (m_data)
    );

    // the clamp never exceeds the configured limit
    a_tlen_clamped: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid |-> m_data.transfer_length <= cfg_reg.transfer_limit)
        else $error("transfer_length above transfer_limit");

    // unknown length reports the limit itself
    a_tlen_unknown: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && !m_data.length_known |-> m_data.transfer_length == cfg_reg.transfer_limit)
        else $error("unknown length not mapped to limit");

    // outcome agrees with status_ok unless the header overflowed
    a_outcome_status: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && m_data.outcome != hrp_pkg::OUTCOME_OVERFLOW
        |-> (m_data.outcome == hrp_pkg::OUTCOME_SUCCESS) == m_data.status_ok)
        else $error("outcome disagrees with status_ok");

    // input only backs up while a byte is held
    a_ready_backpressure: assert property (@(posedge aclk) disable iff (!aresetn)
        !s_ready |-> item_valid && !out_free)
        else $error("s_ready low with empty input register");

    // reset empties the result register
    a_reset_empty: assert property (@(posedge aclk)
        !aresetn |=> !m_valid)
        else $error("result valid right after reset");

endmodule
